>>> rtl/core/swd_pkg.sv
// Package for the stack with delete-by-value core.
// Holds depth, field widths, op and status codes, and the shared struct and enum types.
// No dependencies.
`default_nettype none

package swd_pkg;

   localparam int DEPTH      = 128;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int FILL_W     = $clog2(DEPTH + 1);
   localparam int DATA_W     = 32;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int FILL_OUT_W = 8;

   localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam logic signed [DATA_W-1:0] EMPTY_DATA = -32'sd1;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data_out;
      logic [STATUS_W-1:0]      status;
      logic [FILL_OUT_W-1:0]    fill;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic                     dead;
   } cell_type;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_PUSH,
      CMD_POP,
      CMD_MARK,
      CMD_SWAP
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type             cmd;
      logic                     phase;
      logic signed [DATA_W-1:0] value;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SORT,
      S_COUNT
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/stack_with_value_delete_core.sv
// Top level of the stack with delete-by-value: sequencer plus a chain of DEPTH cells.
// Depends on swd_pkg, swd_cell and swd_ctrl.
//
//   channel  ports                  handshake
//   request  req_item (req_type)    start high, busy low at the clock edge
//   result   rsp_item (rsp_type)    rsp_strobe high for one cycle, no stall
//
// Push, pop and unused ops are done at acceptance; the result is registered and
// appears in the cycle after acceptance and busy stays low, so such transactions
// may come every cycle. Delete holds busy for DEPTH odd-even swap rounds over the
// cell chain, then a walk over the kept entries finds the new fill.
// Synchronous reset empties the stack; entry contents are not cleared.
`default_nettype none

module stack_with_value_delete_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire swd_pkg::req_type req_item,
   output logic                  busy,
   output logic                  rsp_strobe,
   output swd_pkg::rsp_type      rsp_item
);

   swd_pkg::cell_ctl_type      cell_ctl;
   swd_pkg::cell_type          cells [swd_pkg::DEPTH];
   logic [swd_pkg::DEPTH-1:0]  dead_vec;
   logic [swd_pkg::FILL_W-1:0] fill;
   swd_pkg::cell_type          top_feed;
   swd_pkg::cell_type          bottom_feed;

   assign top_feed.data    = cell_ctl.value;
   assign top_feed.dead    = 1'b0;
   assign bottom_feed.data = '0;
   assign bottom_feed.dead = 1'b1;

   swd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req_item),
      .top_data   (cells[0].data),
      .dead_vec   (dead_vec),
      .busy       (busy),
      .fill       (fill),
      .cell_ctl   (cell_ctl),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   for (genvar i = 0; i < swd_pkg::DEPTH; i++) begin : g_cell
      swd_pkg::cell_type above;
      swd_pkg::cell_type below;
      logic              occupied;

      if (i == 0) begin : g_first
         assign above = top_feed;
      end else begin : g_mid_above
         assign above = cells[i-1];
      end

      if (i == swd_pkg::DEPTH - 1) begin : g_last
         assign below = bottom_feed;
      end else begin : g_mid_below
         assign below = cells[i+1];
      end

      assign occupied    = (swd_pkg::FILL_W'(i) < fill);
      assign dead_vec[i] = cells[i].dead;

      swd_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .above     (above),
         .below     (below),
         .occupied  (occupied),
         .index_odd (1'(i % 2)),
         .entry     (cells[i])
      );
   end

endmodule

`default_nettype wire

>>> rtl/core/swd_cell.sv
// One stack cell: holds one entry and a delete mark, trades with both neighbors.
// Depends on swd_pkg.
`default_nettype none

module swd_cell (
   input  wire logic                  clock,
   input  wire swd_pkg::cell_ctl_type ctl,
   input  wire swd_pkg::cell_type     above,
   input  wire swd_pkg::cell_type     below,
   input  wire logic                  occupied,
   input  wire logic                  index_odd,
   output swd_pkg::cell_type          entry
);

   swd_pkg::cell_type cell_ff;
   swd_pkg::cell_type cell_in;

   always_comb begin
      cell_in = cell_ff;
      unique case (ctl.cmd)
         swd_pkg::CMD_HOLD: cell_in = cell_ff;
         swd_pkg::CMD_PUSH: cell_in = above;
         swd_pkg::CMD_POP:  cell_in = below;
         swd_pkg::CMD_MARK: begin
            cell_in.dead = !occupied || (cell_ff.data == ctl.value);
         end
         swd_pkg::CMD_SWAP: begin
            if (index_odd == ctl.phase) begin
               if (cell_ff.dead && !below.dead) cell_in = below;
            end else begin
               if (above.dead && !cell_ff.dead) cell_in = above;
            end
         end
         default: cell_in = cell_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign entry = cell_ff;

endmodule

`default_nettype wire

>>> rtl/core/swd_ctrl.sv
// Sequencer: fill count, push/pop decisions, delete sort rounds and kept-count walk.
// Drives the cell chain command and the registered result. Depends on swd_pkg.
`default_nettype none

module swd_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire swd_pkg::req_type                 req,
   input  wire logic signed [swd_pkg::DATA_W-1:0] top_data,
   input  wire logic [swd_pkg::DEPTH-1:0]        dead_vec,
   output logic                                  busy,
   output logic [swd_pkg::FILL_W-1:0]            fill,
   output swd_pkg::cell_ctl_type                 cell_ctl,
   output logic                                  rsp_strobe,
   output swd_pkg::rsp_type                      rsp_item
);

   swd_pkg::state_type state_ff, state_in;
   logic [swd_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [swd_pkg::IDX_W-1:0]  round_ff, round_in;
   logic [swd_pkg::FILL_W-1:0] k_ff, k_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;
   swd_pkg::rsp_type           rsp_ff, rsp_in;

   logic accept;
   logic last_round;
   logic walk_done;

   assign busy       = (state_ff != swd_pkg::S_IDLE);
   assign accept     = start && !busy;
   assign last_round = (round_ff == swd_pkg::IDX_W'(swd_pkg::DEPTH - 1));
   assign walk_done  = (k_ff == swd_pkg::FILL_W'(swd_pkg::DEPTH))
                       || dead_vec[k_ff[swd_pkg::IDX_W-1:0]];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         swd_pkg::S_IDLE: begin
            if (accept && req.op == swd_pkg::OP_DELETE) state_in = swd_pkg::S_SORT;
         end
         swd_pkg::S_SORT: begin
            if (last_round) state_in = swd_pkg::S_COUNT;
         end
         swd_pkg::S_COUNT: begin
            if (walk_done) state_in = swd_pkg::S_IDLE;
         end
         default: state_in = swd_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      fill_in        = fill_ff;
      round_in       = round_ff;
      k_in           = k_ff;
      rsp_strobe_in  = 1'b0;
      rsp_in         = '0;
      cell_ctl.cmd   = swd_pkg::CMD_HOLD;
      cell_ctl.phase = round_ff[0];
      cell_ctl.value = req.value;
      unique case (state_ff)
         swd_pkg::S_IDLE: begin
            if (accept) begin
               rsp_strobe_in = (req.op != swd_pkg::OP_DELETE);
               case (req.op)
                  swd_pkg::OP_PUSH: begin
                     if (fill_ff == swd_pkg::FILL_W'(swd_pkg::DEPTH)) begin
                        rsp_in.status = swd_pkg::ST_FULL;
                     end else begin
                        cell_ctl.cmd = swd_pkg::CMD_PUSH;
                        fill_in      = fill_ff + 1'b1;
                     end
                  end
                  swd_pkg::OP_POP: begin
                     if (fill_ff == '0) begin
                        rsp_in.data_out = swd_pkg::EMPTY_DATA;
                        rsp_in.status   = swd_pkg::ST_EMPTY;
                     end else begin
                        rsp_in.data_out = top_data;
                        cell_ctl.cmd    = swd_pkg::CMD_POP;
                        fill_in         = fill_ff - 1'b1;
                     end
                  end
                  swd_pkg::OP_DELETE: begin
                     cell_ctl.cmd = swd_pkg::CMD_MARK;
                     round_in     = '0;
                  end
                  default: ;
               endcase
            end
         end
         swd_pkg::S_SORT: begin
            cell_ctl.cmd = swd_pkg::CMD_SWAP;
            round_in     = round_ff + 1'b1;
            if (last_round) k_in = '0;
         end
         swd_pkg::S_COUNT: begin
            if (walk_done) begin
               fill_in       = k_ff;
               rsp_strobe_in = 1'b1;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         default: ;
      endcase
      rsp_in.fill     = swd_pkg::FILL_OUT_W'(fill_in);
      rsp_in.is_empty = (fill_in == '0);
      rsp_in.is_full  = (fill_in == swd_pkg::FILL_W'(swd_pkg::DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= swd_pkg::S_IDLE;
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      round_ff <= round_in;
      k_ff     <= k_in;
      rsp_ff   <= rsp_in;
   end

   assign fill       = fill_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= swd_pkg::FILL_W'(swd_pkg::DEPTH))
      else $error("fill count above depth");

   a_sort_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == swd_pkg::S_SORT |=> state_ff == swd_pkg::S_SORT
                                      || state_ff == swd_pkg::S_COUNT)
      else $error("sort rounds left to wrong state");

   a_strobe_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(accept && req.op != swd_pkg::OP_DELETE)
                        || $past(state_ff == swd_pkg::S_COUNT))
      else $error("result strobe without a finished transaction");

   a_delete_no_grow: assert property (@(posedge clock) disable iff (reset)
      state_ff == swd_pkg::S_COUNT && walk_done |=> fill_ff <= $past(fill_ff))
      else $error("delete increased fill count");

endmodule

`default_nettype wire
